/* hw/rtl/msk_pkg.sv */
// msk_pkg: shared types and widths for the merge sort by key block
// no dependencies; imported by merge_sort_by_key
`default_nettype none

package msk_pkg;

    localparam int KEY_W = 32;
    localparam int TAG_W = 16;

    // sequencer states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PASS,
        ST_MERGE,
        ST_OUT
    } msk_state_t;

endpackage

`default_nettype wire

/* hw/rtl/merge_sort_by_key.sv */
// merge_sort_by_key: store, bottom-up merge sort and ordered readout of keyed items
// depends on msk_pkg (widths, sequencer state type)
`default_nettype none

// channel   handshake                    payload
// -------   --------------------------   -------------------------------------------
// load      load_valid / load_ready      sort_key, item_tag, final_item
// result    result_valid / result_ready  sorted_key, sorted_tag, end_of_run, overflow
//
// loading accepts a request whenever load_valid is high; load_ready is high only while loading
// the request marked final starts the sort over the n stored items: ceil(log2 n)
// merge passes, each opened in ST_PASS and then run in ST_MERGE, one element written per
// cycle, then ST_PASS leaves the pass loop; results then leave at one per cycle while result_ready
// a full result register stalls the readout counter and nothing else is lost
// reset clears control state only; stores are never cleared

module merge_sort_by_key #(
    parameter int MAX_ITEMS = 64
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              load_valid,
    output logic                             load_ready,
    input  wire logic signed [msk_pkg::KEY_W-1:0] sort_key,
    input  wire logic [msk_pkg::TAG_W-1:0]   item_tag,
    input  wire                              final_item,
    output logic                             result_valid,
    input  wire                              result_ready,
    output logic signed [msk_pkg::KEY_W-1:0] sorted_key,
    output logic [msk_pkg::TAG_W-1:0]        sorted_tag,
    output logic                             end_of_run,
    output logic                             overflow
);
    import msk_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);  // store address
    localparam int CW = AW + 1;             // counts and run bounds up to MAX_ITEMS
    localparam int SW = AW + 2;             // run bound sums before clipping

    // two ping-pong banks; each pass reads one and writes the other
    logic [KEY_W-1:0] bank0_key [MAX_ITEMS];
    logic [TAG_W-1:0] bank0_tag [MAX_ITEMS];
    logic [KEY_W-1:0] bank1_key [MAX_ITEMS];
    logic [TAG_W-1:0] bank1_tag [MAX_ITEMS];

    logic [KEY_W-1:0] b0_key_a_reg, b0_key_b_reg, b1_key_a_reg, b1_key_b_reg;
    logic [TAG_W-1:0] b0_tag_a_reg, b0_tag_b_reg, b1_tag_a_reg, b1_tag_b_reg;

    msk_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] width_reg, width_next;
    logic          src_reg, src_next;
    logic [CW-1:0] a_reg, a_next;       // left run cursor, also readout index
    logic [CW-1:0] b_reg, b_next;       // right run cursor
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] right_reg, right_next;
    logic [AW-1:0] pos_reg, pos_next;   // write position in the destination bank
    logic          result_valid_reg, result_valid_next;

    logic signed [KEY_W-1:0] sorted_key_reg;
    logic [TAG_W-1:0]        sorted_tag_reg;
    logic                    end_of_run_reg;
    logic                    overflow_reg;

    // memory port control
    logic             wr0_en, wr1_en;
    logic [AW-1:0]    wr_addr;
    logic [KEY_W-1:0] wr_key;
    logic [TAG_W-1:0] wr_tag;
    logic [AW-1:0]    rd_a_addr, rd_b_addr;

    // merge datapath
    logic [KEY_W-1:0] key_a, key_b;
    logic [TAG_W-1:0] tag_a, tag_b;
    logic             a_live, b_live, take_a;
    logic [CW-1:0]    a_adv, b_adv;
    logic [SW-1:0]    base, sum_mid, sum_right;
    logic [CW-1:0]    mid_clip, right_clip;
    logic             load_fire, room, out_load, last_out;

    // ---- memories: one write port, two registered read ports per bank ----
    always_ff @(posedge clk)
    begin
        if (wr0_en)
        begin
            bank0_key[wr_addr] <= wr_key;
            bank0_tag[wr_addr] <= wr_tag;
        end
        b0_key_a_reg <= bank0_key[rd_a_addr];
        b0_tag_a_reg <= bank0_tag[rd_a_addr];
        b0_key_b_reg <= bank0_key[rd_b_addr];
        b0_tag_b_reg <= bank0_tag[rd_b_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr1_en)
        begin
            bank1_key[wr_addr] <= wr_key;
            bank1_tag[wr_addr] <= wr_tag;
        end
        b1_key_a_reg <= bank1_key[rd_a_addr];
        b1_tag_a_reg <= bank1_tag[rd_a_addr];
        b1_key_b_reg <= bank1_key[rd_b_addr];
        b1_tag_b_reg <= bank1_tag[rd_b_addr];
    end

    // read addresses follow the next cursors so data lines up with the cursor registers
    assign rd_a_addr = a_next[AW-1:0];
    assign rd_b_addr = b_next[AW-1:0];

    // source bank select
    assign key_a = src_reg ? b1_key_a_reg : b0_key_a_reg;
    assign key_b = src_reg ? b1_key_b_reg : b0_key_b_reg;
    assign tag_a = src_reg ? b1_tag_a_reg : b0_tag_a_reg;
    assign tag_b = src_reg ? b1_tag_b_reg : b0_tag_b_reg;

    // shared compare: right run wins ties
    assign a_live = (a_reg < mid_reg);
    assign b_live = (b_reg < right_reg);
    assign take_a = a_live && (!b_live || ($signed(key_a) < $signed(key_b)));
    assign a_adv  = a_reg + CW'(take_a);
    assign b_adv  = b_reg + CW'(!take_a);

    // bounds of the next run pair, clipped to n
    assign base       = (state_reg == ST_PASS) ? '0 : SW'(right_reg);
    assign sum_mid    = base + SW'(width_reg);
    assign sum_right  = base + (SW'(width_reg) << 1);
    assign mid_clip   = (sum_mid   > SW'(n_reg)) ? n_reg : sum_mid[CW-1:0];
    assign right_clip = (sum_right > SW'(n_reg)) ? n_reg : sum_right[CW-1:0];

    assign load_ready = (state_reg == ST_LOAD);
    assign load_fire  = load_valid && load_ready;
    assign room       = (count_reg < CW'(MAX_ITEMS));
    assign out_load   = (state_reg == ST_OUT) && (!result_valid_reg || result_ready);
    assign last_out   = ((a_reg + CW'(1)) == n_reg);

    // ---- control registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            count_reg        <= '0;
            ovf_reg          <= 1'b0;
            n_reg            <= '0;
            width_reg        <= '0;
            src_reg          <= 1'b0;
            a_reg            <= '0;
            b_reg            <= '0;
            mid_reg          <= '0;
            right_reg        <= '0;
            pos_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            ovf_reg          <= ovf_next;
            n_reg            <= n_next;
            width_reg        <= width_next;
            src_reg          <= src_next;
            a_reg            <= a_next;
            b_reg            <= b_next;
            mid_reg          <= mid_next;
            right_reg        <= right_next;
            pos_reg          <= pos_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // ---- sequencer ----
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        ovf_next          = ovf_reg;
        n_next            = n_reg;
        width_next        = width_reg;
        src_next          = src_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        mid_next          = mid_reg;
        right_next        = right_reg;
        pos_next          = pos_reg;
        result_valid_next = result_valid_reg && !result_ready;
        wr0_en            = 1'b0;
        wr1_en            = 1'b0;
        wr_addr           = pos_reg;
        wr_key            = take_a ? key_a : key_b;
        wr_tag            = take_a ? tag_a : tag_b;

        unique case (state_reg)
            ST_LOAD:
            begin
                wr_addr = count_reg[AW-1:0];
                wr_key  = sort_key;
                wr_tag  = item_tag;
                if (load_fire)
                begin
                    if (room)
                    begin
                        wr0_en     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (final_item)
                    begin
                        n_next     = count_next;
                        width_next = CW'(1);
                        src_next   = 1'b0;
                        state_next = ST_PASS;
                    end
                end
            end
            ST_PASS:
            begin
                // open a pass, or finish once one run covers everything
                a_next = '0;
                if (width_reg >= n_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    b_next     = mid_clip;
                    mid_next   = mid_clip;
                    right_next = right_clip;
                    pos_next   = '0;
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                // one element into the destination bank per cycle
                wr0_en   = src_reg;
                wr1_en   = !src_reg;
                pos_next = pos_reg + AW'(1);
                a_next   = a_adv;
                b_next   = b_adv;
                if ((a_adv == mid_reg) && (b_adv == right_reg))
                begin
                    if (right_reg == n_reg)
                    begin
                        width_next = width_reg << 1;
                        src_next   = !src_reg;
                        state_next = ST_PASS;
                    end
                    else
                    begin
                        // next run pair starts where this one ended
                        a_next     = right_reg;
                        b_next     = mid_clip;
                        mid_next   = mid_clip;
                        right_next = right_clip;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    result_valid_next = 1'b1;
                    a_next            = a_reg + CW'(1);
                    if (last_out)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end
        endcase
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            sorted_key_reg <= $signed(key_a);
            sorted_tag_reg <= tag_a;
            end_of_run_reg <= last_out;
            overflow_reg   <= ovf_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign sorted_key   = sorted_key_reg;
    assign sorted_tag   = sorted_tag_reg;
    assign end_of_run   = end_of_run_reg;
    assign overflow     = overflow_reg;

endmodule

`default_nettype wire
